// File: rtl/lseg_pkg.sv
// ----------------------------------------------------------------------------
// lseg_pkg
// shared types, constants and helpers of the led strip effect generator
// ----------------------------------------------------------------------------
`default_nettype none
package lseg_pkg;
	localparam int MaxLeds = 64;
	localparam int PixW = $clog2(MaxLeds);
	localparam int CntW = PixW + 1;

	localparam logic [0:0] CMD_START = 1'b0;
	localparam logic [0:0] CMD_NEXT = 1'b1;

	localparam logic [0:0] REG_LED_COUNT = 1'b0;
	localparam logic [0:0] REG_BRIGHTNESS = 1'b1;

	localparam logic [3:0] EV_RAINBOW = 4'd0;
	localparam logic [3:0] EV_GREEN = 4'd1;
	localparam logic [3:0] EV_BLINK_RED = 4'd2;
	localparam logic [3:0] EV_CYAN = 4'd3;
	localparam logic [3:0] EV_BLINK_ORANGE = 4'd4;
	localparam logic [3:0] EV_PURPLE = 4'd5;
	localparam logic [3:0] EV_BLINK_PURPLE = 4'd6;
	localparam logic [3:0] EV_CHASE_YELLOW = 4'd7;
	localparam logic [3:0] EV_CHASE_WHITE = 4'd8;
	localparam logic [3:0] EV_BLINK_GREEN = 4'd9;
	localparam logic [3:0] EV_BLINK_RED2 = 4'd10;
	localparam logic [3:0] EV_BREATH_GOLD = 4'd11;
	localparam logic [3:0] EV_BREATH_RED = 4'd12;
	localparam logic [3:0] EV_ALERT = 4'd13;
	localparam logic [3:0] EV_CUSTOM = 4'd14;
	localparam logic [3:0] EV_OFF = 4'd15;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	// x*y/255 for 16-bit x*y, exact: (p + 1 + (p >> 8)) >> 8
	function automatic logic [7:0] div255(input logic [15:0] p);
		logic [16:0] t;
		t = {1'b0, p} + 17'd1 + {9'd0, p[15:8]};
		return t[15:8];
	endfunction

	// floor(k*255/6) for k 0..6
	function automatic logic [7:0] ramp(input logic [2:0] k);
		case (k)
			3'd0: ramp = 8'd0;
			3'd1: ramp = 8'd42;
			3'd2: ramp = 8'd85;
			3'd3: ramp = 8'd127;
			3'd4: ramp = 8'd170;
			3'd5: ramp = 8'd212;
			3'd6: ramp = 8'd255;
			default: ramp = 8'd0;
		endcase
	endfunction
endpackage
`default_nettype wire

// File: rtl/led_strip_effect_generator_core.sv
// ----------------------------------------------------------------------------
// led_strip_effect_generator_core
// effect sequencer: per pixel color lookup, then channel scaling on one
// shared multiplier under a small step sequencer
// a start item loads the effect and yields no result; a next item goes ST_CALC,
// six ST_MUL passes, ST_DONE, ST_OUT, or ST_CALC to ST_OUT when idle; one item at a time
// reset: idle, led_count 8, brightness 255, no effect running
// ----------------------------------------------------------------------------
`default_nettype none
module led_strip_effect_generator_core (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic command,
	input wire logic [3:0] event_code,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic cfg_index,
	input wire logic [7:0] cfg_data,
	output logic out_valid,
	input wire logic out_ready,
	output logic [5:0] pixel_index,
	output logic [7:0] red_level,
	output logic [7:0] green_level,
	output logic [7:0] blue_level,
	output logic frame_end,
	output logic [9:0] hold_ms,
	output logic effect_done
);
	import lseg_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_CALC = 5'b00010,
		ST_MUL = 5'b00100,
		ST_DONE = 5'b01000,
		ST_OUT = 5'b10000
	} state_t;

	state_t state_q;
	logic [6:0] led_count_q;
	logic [7:0] bright_q;
	logic busy_q;
	logic [3:0] kind_q;
	logic [8:0] frame_q;
	logic [PixW-1:0] pix_q;
	logic [2:0] step_q;
	logic [3:0] tick_q;
	rgb_t col_q;
	logic [7:0] lvl_q;
	logic [9:0] hold_q;
	logic lastf_q, lastp_q, idle_q;
	logic [7:0] mul_a, mul_b, mul_q;
	logic [7:0] res_q [3];

	// effective strip length
	logic [CntW-1:0] n;
	always_comb begin
		if (led_count_q == 7'd0)
			n = CntW'(1);
		else if (led_count_q > 7'(MaxLeds))
			n = CntW'(MaxLeds);
		else
			n = CntW'(led_count_q);
	end

	logic [8:0] total;
	always_comb begin
		case (kind_q)
			EV_RAINBOW: total = 9'd37;
			EV_GREEN, EV_CYAN, EV_PURPLE, EV_CUSTOM: total = 9'd2;
			EV_BLINK_RED, EV_BLINK_ORANGE, EV_BLINK_PURPLE: total = 9'd6;
			EV_BLINK_GREEN, EV_BLINK_RED2: total = 9'd4;
			EV_CHASE_YELLOW, EV_CHASE_WHITE:
				total = 9'({n, 2'b00} + {n, 1'b0} + 9'd1);
			EV_BREATH_GOLD, EV_BREATH_RED: total = 9'd105;
			EV_ALERT: total = 9'd11;
			default: total = 9'd1;
		endcase
	end
	wire last_frame = frame_q >= total - 9'd1;
	wire last_pixel = {1'b0, pix_q} >= n - CntW'(1);

	// rainbow hue position: hue/60 = f/6 + p, hue mod 60 = 10*(f mod 6)
	logic [5:0] f_div6;
	logic [2:0] f_mod6;
	logic [2:0] sect;
	logic [7:0] up, dn;
	logic [8:0] fm;
	logic [7:0] hsum, hq, hm;
	always_comb begin
		f_div6 = 6'((16'(frame_q) * 16'd43) >> 8);
		fm = frame_q - 9'({f_div6, 2'b00} + {f_div6, 1'b0});
		f_mod6 = fm[2:0];
		hsum = {2'b0, f_div6} + {2'b0, pix_q};
		hq = 8'((16'(hsum) * 16'd43) >> 8);
		hm = hsum - 8'({hq, 2'b00} + {hq, 1'b0});
		sect = hm[2:0];
		up = ramp(f_mod6);
		dn = ramp(3'd6 - f_mod6);
	end

	// chase lit position, frame below 6n outside the dark frame
	logic [8:0] pos, two_n, four_n;
	logic [8:0] lit;
	always_comb begin
		two_n = 9'({n, 1'b0});
		four_n = 9'({n, 2'b00});
		if (frame_q >= four_n)
			pos = frame_q - four_n;
		else if (frame_q >= two_n)
			pos = frame_q - two_n;
		else
			pos = frame_q;
		lit = (pos < 9'(n)) ? pos : two_n - 9'd1 - pos;
	end

	rgb_t col;
	logic [7:0] lvl;
	logic [9:0] hold;
	always_comb begin
		col = '0;
		lvl = 8'd255;
		hold = 10'd0;
		case (kind_q)
			EV_RAINBOW: begin
				case (sect)
					3'd0: col = '{8'd255, up, 8'd0};
					3'd1: col = '{dn, 8'd255, 8'd0};
					3'd2: col = '{8'd0, 8'd255, up};
					3'd3: col = '{8'd0, dn, 8'd255};
					3'd4: col = '{up, 8'd0, 8'd255};
					default: col = '{8'd255, 8'd0, dn};
				endcase
				hold = 10'd50;
			end
			EV_GREEN: begin col = '{8'd0, 8'd255, 8'd0}; hold = 10'd1000; end
			EV_CYAN: begin col = '{8'd0, 8'd255, 8'd255}; hold = 10'd1000; end
			EV_PURPLE: begin col = '{8'd128, 8'd0, 8'd128}; hold = 10'd1000; end
			EV_CUSTOM: begin col = '{8'd128, 8'd128, 8'd128}; hold = 10'd500; end
			EV_BLINK_RED, EV_BLINK_ORANGE, EV_BLINK_PURPLE, EV_BLINK_GREEN,
			EV_BLINK_RED2: begin
				if (!frame_q[0]) begin
					case (kind_q)
						EV_BLINK_ORANGE: col = '{8'd255, 8'd90, 8'd0};
						EV_BLINK_PURPLE: col = '{8'd128, 8'd0, 8'd128};
						EV_BLINK_GREEN: col = '{8'd0, 8'd255, 8'd0};
						default: col = '{8'd255, 8'd0, 8'd0};
					endcase
				end
				hold = 10'd200;
			end
			EV_CHASE_YELLOW, EV_CHASE_WHITE: begin
				if (9'(pix_q) == lit)
					col = (kind_q == EV_CHASE_YELLOW) ? rgb_t'{8'd255, 8'd255, 8'd0}
						: rgb_t'{8'd255, 8'd255, 8'd255};
				hold = 10'd100;
			end
			EV_BREATH_GOLD, EV_BREATH_RED: begin
				col = (kind_q == EV_BREATH_GOLD) ? rgb_t'{8'd255, 8'd215, 8'd0}
					: rgb_t'{8'd255, 8'd0, 8'd0};
				lvl = (frame_q < 9'd52) ? 8'(frame_q * 9'd5)
					: 8'((9'd103 - frame_q) * 9'd5);
				hold = 10'd30;
			end
			EV_ALERT: begin
				col = frame_q[0] ? rgb_t'{8'd0, 8'd0, 8'd255} : rgb_t'{8'd255, 8'd0, 8'd0};
				hold = 10'd200;
			end
			default: ;
		endcase
		if (last_frame) begin
			col = '0;
			hold = 10'd0;
		end
	end

	// steps 0..2 level pass per channel, 3..5 brightness pass
	logic [1:0] ch;
	assign ch = (step_q >= 3'd3) ? 2'(step_q - 3'd3) : 2'(step_q);
	always_comb begin
		if (step_q < 3'd3) begin
			mul_a = (ch == 2'd0) ? col_q.r : (ch == 2'd1) ? col_q.g : col_q.b;
			mul_b = lvl_q;
		end else begin
			mul_a = res_q[ch];
			mul_b = bright_q;
		end
	end

	lseg_scaler u_scaler (.clk(clk), .a(mul_a), .b(mul_b), .q(mul_q));

	assign in_ready = (state_q == ST_IDLE) && !cfg_valid;
	assign cfg_ready = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			led_count_q <= 7'd8;
			bright_q <= 8'd255;
			busy_q <= 1'b0;
			kind_q <= '0;
			frame_q <= '0;
			pix_q <= '0;
			step_q <= '0;
			tick_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cfg_valid) begin
						if (cfg_index == REG_LED_COUNT) led_count_q <= cfg_data[6:0];
						else if (cfg_index == REG_BRIGHTNESS) bright_q <= cfg_data;
					end else if (in_valid) begin
						if (command == CMD_START) begin
							busy_q <= 1'b1;
							kind_q <= event_code;
							frame_q <= '0;
							pix_q <= '0;
						end else begin
							state_q <= ST_CALC;
						end
					end
				end
				ST_CALC: begin
					step_q <= '0;
					tick_q <= '0;
					state_q <= busy_q ? ST_MUL : ST_OUT;
				end
				ST_MUL: begin
					// issue, then capture the registered product in the next cycle
					tick_q <= tick_q + 4'd1;
					if (tick_q[0]) begin
						step_q <= step_q + 3'd1;
						if (step_q == 3'd5) state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (lastp_q) begin
						pix_q <= '0;
						if (lastf_q) begin
							busy_q <= 1'b0;
							frame_q <= '0;
						end else begin
							frame_q <= frame_q + 9'd1;
						end
					end else begin
						pix_q <= pix_q + PixW'(1);
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_ready) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_CALC: begin
				col_q <= col;
				lvl_q <= lvl;
				hold_q <= hold;
				lastf_q <= last_frame;
				lastp_q <= last_pixel;
				idle_q <= !busy_q;
				pixel_index <= 6'(pix_q);
				if (!busy_q) begin
					red_level <= '0;
					green_level <= '0;
					blue_level <= '0;
					frame_end <= 1'b0;
					hold_ms <= '0;
					effect_done <= 1'b0;
					pixel_index <= '0;
				end
			end
			ST_MUL: begin
				if (tick_q[0]) res_q[ch] <= mul_q;
			end
			ST_DONE: begin
				red_level <= res_q[0];
				green_level <= res_q[1];
				blue_level <= res_q[2];
				frame_end <= lastp_q;
				hold_ms <= lastp_q ? hold_q : 10'd0;
				effect_done <= lastp_q & lastf_q;
			end
			default: ;
		endcase
	end

	property p_no_result_on_start;
		@(posedge clk) disable iff (!arst_n)
			(in_valid && in_ready && command == CMD_START) |=> !out_valid;
	endproperty
	a_no_result_on_start: assert property (p_no_result_on_start)
		else $error("result after start item");

	a_done_has_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && effect_done) |-> frame_end)
		else $error("effect_done without frame_end");

	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && idle_q) |-> (red_level == 8'd0 && hold_ms == 10'd0))
		else $error("idle result not zero");

	a_hold_only_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !frame_end) |-> hold_ms == 10'd0)
		else $error("hold without frame end");
endmodule
`default_nettype wire

// File: rtl/lseg_scaler.sv
// ----------------------------------------------------------------------------
// lseg_scaler
// shared 8x8 multiplier with exact divide by 255, one product per cycle
// ----------------------------------------------------------------------------
`default_nettype none
module lseg_scaler (
	input wire logic clk,
	input wire logic [7:0] a,
	input wire logic [7:0] b,
	output logic [7:0] q
);
	import lseg_pkg::*;
	logic [15:0] prod_q;
	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end
	assign q = div255(prod_q);
endmodule
`default_nettype wire

// File: tb/led_strip_effect_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_strip_effect_checker
// watches the command, register and pixel channels of the effect generator,
// predicts every pixel from its own model of the effect sequencer and
// compares each accepted pixel, all fields at once, with the oldest prediction
// ----------------------------------------------------------------------------
`default_nettype none
module led_strip_effect_checker
	import lseg_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic command,
	input wire logic [3:0] event_code,
	input wire logic cfg_valid,
	input wire logic cfg_ready,
	input wire logic cfg_index,
	input wire logic [7:0] cfg_data,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic [5:0] pixel_index,
	input wire logic [7:0] red_level,
	input wire logic [7:0] green_level,
	input wire logic [7:0] blue_level,
	input wire logic frame_end,
	input wire logic [9:0] hold_ms,
	input wire logic effect_done,
	output int fail_count,
	output int pending
);
	typedef struct packed {
		logic [5:0] idx;
		rgb_t color;
		logic fe;
		logic [9:0] hold;
		logic done;
	} pixel_t;

	pixel_t pixels_due[$];
	logic [6:0] strip_len;
	logic [7:0] bright;
	logic running;
	logic [3:0] kind;
	logic [8:0] frame;
	logic [5:0] pix;

	function automatic int unsigned strip_n(input logic [6:0] v);
		if (v == 0) return 1;
		if (v > MaxLeds) return MaxLeds;
		return v;
	endfunction

	function automatic int unsigned frames_of(input logic [3:0] k, input int unsigned n);
		case (k)
			EV_RAINBOW: return 37;
			EV_GREEN, EV_CYAN, EV_PURPLE, EV_CUSTOM: return 2;
			EV_BLINK_RED, EV_BLINK_ORANGE, EV_BLINK_PURPLE: return 6;
			EV_BLINK_GREEN, EV_BLINK_RED2: return 4;
			EV_CHASE_YELLOW, EV_CHASE_WHITE: return 6 * n + 1;
			EV_BREATH_GOLD, EV_BREATH_RED: return 105;
			EV_ALERT: return 11;
			default: return 1;
		endcase
	endfunction

	task automatic predict_next();
		pixel_t p;
		int unsigned n, tot, hold, hue, s, k, up, dn, lvl, pos, lit, f, i;
		int unsigned r, g, b;
		logic last_f, last_p;
		p = '0;
		if (!running) begin
			pixels_due.push_back(p);
			return;
		end
		n = strip_n(strip_len);
		tot = frames_of(kind, n);
		f = frame;
		i = pix;
		last_f = f >= tot - 1;
		last_p = i >= n - 1;
		r = 0; g = 0; b = 0; hold = 0;
		if (!last_f) begin
			case (kind)
				EV_RAINBOW: begin
					hue = 10 * f + 60 * i;
					s = (hue / 60) % 6;
					k = (hue % 60) / 10;
					up = k * 255 / 6;
					dn = (6 - k) * 255 / 6;
					case (s)
						0: begin r = 255; g = up; end
						1: begin r = dn; g = 255; end
						2: begin g = 255; b = up; end
						3: begin g = dn; b = 255; end
						4: begin r = up; b = 255; end
						default: begin r = 255; b = dn; end
					endcase
					hold = 50;
				end
				EV_GREEN: begin g = 255; hold = 1000; end
				EV_CYAN: begin g = 255; b = 255; hold = 1000; end
				EV_PURPLE: begin r = 128; b = 128; hold = 1000; end
				EV_CUSTOM: begin r = 128; g = 128; b = 128; hold = 500; end
				EV_BLINK_RED, EV_BLINK_ORANGE, EV_BLINK_PURPLE, EV_BLINK_GREEN,
						EV_BLINK_RED2: begin
					if (f[0] == 0) begin
						if (kind == EV_BLINK_ORANGE) begin r = 255; g = 90; end
						else if (kind == EV_BLINK_PURPLE) begin r = 128; b = 128; end
						else if (kind == EV_BLINK_GREEN) g = 255;
						else r = 255;
					end
					hold = 200;
				end
				EV_CHASE_YELLOW, EV_CHASE_WHITE: begin
					pos = f % (2 * n);
					lit = (pos < n) ? pos : 2 * n - 1 - pos;
					if (i == lit) begin
						r = 255; g = 255;
						if (kind == EV_CHASE_WHITE) b = 255;
					end
					hold = 100;
				end
				EV_BREATH_GOLD, EV_BREATH_RED: begin
					lvl = (f < 52) ? 5 * f : 5 * (103 - f);
					r = 255 * lvl / 255;
					if (kind == EV_BREATH_GOLD) g = 215 * lvl / 255;
					hold = 30;
				end
				EV_ALERT: begin
					if (f[0] == 0) r = 255;
					else b = 255;
					hold = 200;
				end
				default: ;
			endcase
		end
		p.idx = pix;
		p.color.r = 8'(r * bright / 255);
		p.color.g = 8'(g * bright / 255);
		p.color.b = 8'(b * bright / 255);
		p.fe = last_p;
		p.hold = last_p ? hold[9:0] : 10'd0;
		p.done = last_f && last_p;
		pixels_due.push_back(p);
		if (last_p) begin
			pix = '0;
			if (last_f) begin
				running = 1'b0;
				frame = '0;
			end else begin
				frame = frame + 9'd1;
			end
		end else begin
			pix = pix + 6'd1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		pixel_t got, want;
		if (!arst_n) begin
			pixels_due.delete();
			strip_len = 7'd8;
			bright = 8'd255;
			running = 1'b0;
			kind = '0;
			frame = '0;
			pix = '0;
			fail_count = 0;
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_LED_COUNT) strip_len = cfg_data[6:0];
				else bright = cfg_data;
			end
			if (in_valid && in_ready) begin
				if (command == CMD_START) begin
					running = 1'b1;
					kind = event_code;
					frame = '0;
					pix = '0;
				end else begin
					predict_next();
				end
			end
			if (out_valid && out_ready) begin
				got = {pixel_index, red_level, green_level, blue_level, frame_end,
					hold_ms, effect_done};
				if (pixels_due.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) $display("unexpected pixel %h", got);
				end else begin
					want = pixels_due.pop_front();
					if (got !== want) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: expected %h got %h", want, got);
					end
				end
			end
			pending = pixels_due.size();
		end
	end
endmodule
`default_nettype wire

// File: tb/led_strip_effect_generator_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_strip_effect_generator_core_tb
// drives effect start and next-pixel items through the generator under
// bursty input and stalling output, rewrites strip length and brightness
// between phases, and reports the checker's verdict
// ----------------------------------------------------------------------------
`default_nettype none
module led_strip_effect_generator_core_tb;
	import lseg_pkg::*;

	logic clk, arst_n;
	logic in_valid, in_ready, command;
	logic [3:0] event_code;
	logic cfg_valid, cfg_ready, cfg_index;
	logic [7:0] cfg_data;
	logic out_valid, out_ready;
	logic [5:0] pixel_index;
	logic [7:0] red_level, green_level, blue_level;
	logic frame_end, effect_done;
	logic [9:0] hold_ms;
	int fail_count, pending;
	int items_sent, burst_left;
	int idle_cycles = 0;
	int unsigned strip_now;
	bit hold_req;

	led_strip_effect_generator_core u_top (.*);

	led_strip_effect_checker u_chk (.*);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		out_ready = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 0;
				repeat (400) @(posedge clk);
				hold_req = 0;
			end else begin
				case ((idle_cycles + items_sent / 50) % 3)
					0: out_ready <= 1;
					1: out_ready <= $urandom_range(0, 1);
					default: out_ready <= ($urandom_range(0, 9) != 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= 3000) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic int unsigned effect_len(input logic [3:0] k, input int unsigned n);
		case (k)
			EV_RAINBOW: return 37 * n;
			EV_GREEN, EV_CYAN, EV_PURPLE, EV_CUSTOM: return 2 * n;
			EV_BLINK_RED, EV_BLINK_ORANGE, EV_BLINK_PURPLE: return 6 * n;
			EV_BLINK_GREEN, EV_BLINK_RED2: return 4 * n;
			EV_CHASE_YELLOW, EV_CHASE_WHITE: return (6 * n + 1) * n;
			EV_BREATH_GOLD, EV_BREATH_RED: return 105 * n;
			EV_ALERT: return 11 * n;
			default: return n;
		endcase
	endfunction

	task automatic send(input logic cmd, input logic [3:0] code);
		int gap;
		if (burst_left <= 0) begin
			gap = $urandom_range(0, 15);
			if (gap > 0) begin
				in_valid <= 0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end
		in_valid <= 1;
		command <= cmd;
		event_code <= code;
		do @(posedge clk); while (!in_ready);
		burst_left--;
		items_sent++;
	endtask

	task automatic drain();
		in_valid <= 0;
		burst_left = 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [7:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		if (idx == REG_LED_COUNT)
			strip_now = (val[6:0] == 0) ? 1 : (val[6:0] > MaxLeds) ? MaxLeds : val[6:0];
		@(posedge clk);
	endtask

	task automatic run_effect(input logic [3:0] code, input int unsigned cap);
		int unsigned len;
		len = effect_len(code, strip_now);
		if (len > cap) len = $urandom_range(1, cap);
		send(CMD_START, code);
		repeat (len) send(CMD_NEXT, 4'($urandom_range(0, 15)));
	endtask

	initial begin
		logic [7:0] v;
		int seqs;
		arst_n = 0;
		in_valid = 0;
		command = 0;
		event_code = 0;
		cfg_valid = 0;
		cfg_index = 0;
		cfg_data = 0;
		items_sent = 0;
		burst_left = 0;
		strip_now = 8;
		hold_req = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// idle next, off effect, start while busy
		send(CMD_NEXT, EV_ALERT);
		send(CMD_START, EV_OFF);
		repeat (9) send(CMD_NEXT, 4'd0);
		drain();
		write_reg(REG_LED_COUNT, 8'd0);
		write_reg(REG_BRIGHTNESS, 8'd0);
		send(CMD_START, EV_GREEN);
		send(CMD_NEXT, 4'd0);
		run_effect(EV_BLINK_RED, 20);
		drain();
		write_reg(REG_LED_COUNT, 8'hff);
		write_reg(REG_BRIGHTNESS, 8'd255);
		send(CMD_START, EV_CHASE_WHITE);
		repeat (3) send(CMD_NEXT, 4'd0);
		drain();
		// strip shrinks mid frame
		write_reg(REG_LED_COUNT, 8'd2);
		repeat (4) send(CMD_NEXT, 4'd0);
		drain();

		hold_req = 1;
		while (items_sent < 1800) begin
			case ($urandom_range(0, 7))
				0: write_reg(REG_LED_COUNT, 8'($urandom_range(0, 255)));
				1: write_reg(REG_LED_COUNT, ($urandom_range(0, 1) != 0) ? 8'd1 : 8'd64);
				default: write_reg(REG_LED_COUNT, 8'($urandom_range(1, 6)));
			endcase
			case ($urandom_range(0, 4))
				0: v = 8'd0;
				1: v = 8'd255;
				default: v = 8'($urandom_range(0, 255));
			endcase
			write_reg(REG_BRIGHTNESS, v);
			seqs = $urandom_range(1, 4);
			repeat (seqs) begin
				if (items_sent < 1800) begin
					if ($urandom_range(0, 9) == 0)
						send(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
					run_effect(4'($urandom_range(0, 15)),
						($urandom_range(0, 3) == 0) ? 40 : 250);
				end
			end
			drain();
		end

		drain();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
`default_nettype wire
